// ===== rtl/dgcd_pkg.sv =====
// Shared types, constants and helpers for the directed graph cycle detector.
// No dependencies; every other file refers to this package by scoped names.
package dgcd_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = 6;
  localparam int DEPTH_W   = 7;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_CHECK = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef logic [MAX_NODES-1:0] row_t;
  typedef logic [NODE_W-1:0]    node_t;
  typedef logic [DEPTH_W-1:0]   depth_t;

  // adjacency memory request
  typedef struct packed {
    logic  rd_en;
    node_t rd_addr;
    logic  wr_en;
    node_t wr_addr;
    logic  clr;
  } adj_req_t;

  // path stack request
  typedef struct packed {
    logic  rd_en;
    node_t rd_addr;
    logic  wr_en;
    node_t wr_addr;
    node_t wr_data;
  } stk_req_t;

  // result of one row scan
  typedef struct packed {
    logic  conflict;
    logic  fresh_any;
    node_t low_idx;
  } scan_res_t;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_ADD_RD1 = 11'b000_0000_0010,
    S_ADD_WR1 = 11'b000_0000_0100,
    S_ADD_RD2 = 11'b000_0000_1000,
    S_ADD_WR2 = 11'b000_0001_0000,
    S_START   = 11'b000_0010_0000,
    S_FETCH   = 11'b000_0100_0000,
    S_EVAL    = 11'b000_1000_0000,
    S_DECIDE  = 11'b001_0000_0000,
    S_POP     = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_t;

  // index of the lowest set bit of a byte, zero when none
  function automatic logic [2:0] lowest8(input logic [7:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/dgcd_adj_mem.sv =====
// Adjacency row memory: one row per source node, registered read port.
// Row valid bits make reset and the clear command empty the graph at once. Uses dgcd_pkg.
module dgcd_adj_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  dgcd_pkg::adj_req_t req,
  input  dgcd_pkg::row_t    wr_data,
  output dgcd_pkg::row_t    rd_data
);

  dgcd_pkg::row_t              rows_r [dgcd_pkg::MAX_NODES];
  logic [dgcd_pkg::MAX_NODES-1:0] row_vld_r;
  dgcd_pkg::row_t              rd_data_r;
  logic                        rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      rows_r[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= rows_r[req.rd_addr];
      rd_vld_r  <= row_vld_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (req.clr) begin
      row_vld_r <= '0;
    end else if (req.wr_en) begin
      row_vld_r[req.wr_addr] <= 1'b1;
    end
  end

  // unwritten rows read as empty
  assign rd_data = rd_data_r & {dgcd_pkg::MAX_NODES{rd_vld_r}};

endmodule

// ===== rtl/dgcd_stack_mem.sv =====
// Path stack memory for the depth-first walk, registered read port.
// Entries are read only after they are written, so no reset. Uses dgcd_pkg.
module dgcd_stack_mem (
  input  logic               clk,
  input  dgcd_pkg::stk_req_t req,
  output dgcd_pkg::node_t    rd_data
);

  dgcd_pkg::node_t mem_r [dgcd_pkg::MAX_NODES];
  dgcd_pkg::node_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/dgcd_scan_unit.sv =====
// Shared row scan unit: compares one adjacency row against the path and visited marks.
// Registers the compare, then finds the lowest unvisited successor in two byte levels.
// Uses dgcd_pkg.
module dgcd_scan_unit (
  input  logic                clk,
  input  logic                ld,
  input  dgcd_pkg::row_t      row,
  input  dgcd_pkg::row_t      node_mask,
  input  dgcd_pkg::row_t      visited,
  input  dgcd_pkg::row_t      on_path,
  output dgcd_pkg::scan_res_t res
);

  logic           conflict_r;
  dgcd_pkg::row_t fresh_r;
  logic [7:0]     grp_any;
  logic [2:0]     grp_idx;
  logic [7:0]     grp_byte;
  logic [2:0]     bit_idx;

  always_ff @(posedge clk) begin
    if (ld) begin
      conflict_r <= |(row & node_mask & on_path);
      fresh_r    <= row & node_mask & ~visited;
    end
  end

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      grp_any[g] = |fresh_r[g*8 +: 8];
    end
    grp_idx  = dgcd_pkg::lowest8(grp_any);
    grp_byte = fresh_r[{grp_idx, 3'b000} +: 8];
    bit_idx  = dgcd_pkg::lowest8(grp_byte);
  end

  assign res.conflict  = conflict_r;
  assign res.fresh_any = |grp_any;
  assign res.low_idx   = {grp_idx, bit_idx};

endmodule

// ===== rtl/directed_graph_cycle_detect.sv =====
// Directed graph cycle detector, top level: request sequencer, walk marks, result register.
// Instantiates dgcd_adj_mem, dgcd_stack_mem and dgcd_scan_unit; uses dgcd_pkg.
//
//   channel | ports                                            | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_stall, in_mode, in_edge_from,       | into block
//           | in_edge_to, in_directed                          |
//   out     | out_valid, out_stall, out_cycle_found            | out of block
//
// A clear or a dropped request ends in the idle state; an add does one row read-modify-write
// per arc, one arc when directed and two when undirected, through the single memory read port.
// A check walks the start nodes; a push fetches, scans and decides (FETCH, EVAL, DECIDE), and
// a pop that resumes a parent reads the stack (POP) before that, all on one scan unit.
// Reset is synchronous; row valid bits empty the graph at once, with no clearing pass.
// in_stall is high while a request works; a stalled check result holds the done state.
module directed_graph_cycle_detect #(
  parameter int NODE_COUNT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [5:0] in_edge_from,
  input  logic [5:0] in_edge_to,
  input  logic       in_directed,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_cycle_found
);

  localparam dgcd_pkg::depth_t NODE_LIMIT = dgcd_pkg::DEPTH_W'(NODE_COUNT);
  localparam dgcd_pkg::row_t   NODE_MASK  = (NODE_COUNT >= dgcd_pkg::MAX_NODES) ?
      {dgcd_pkg::MAX_NODES{1'b1}} :
      ((dgcd_pkg::MAX_NODES'(1) << NODE_COUNT) - dgcd_pkg::MAX_NODES'(1));

  dgcd_pkg::state_t    state_r, state_nxt;
  dgcd_pkg::node_t     from_r, from_nxt;
  dgcd_pkg::node_t     to_r, to_nxt;
  logic                dir_r, dir_nxt;
  dgcd_pkg::row_t      visited_r, visited_nxt;
  dgcd_pkg::row_t      on_path_r, on_path_nxt;
  dgcd_pkg::depth_t    depth_r, depth_nxt;
  dgcd_pkg::depth_t    start_r, start_nxt;
  dgcd_pkg::node_t     top_r, top_nxt;
  logic                found_r, found_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;

  dgcd_pkg::adj_req_t  adj_req;
  dgcd_pkg::row_t      adj_wr_data;
  dgcd_pkg::row_t      adj_rd_data;
  dgcd_pkg::stk_req_t  stk_req;
  dgcd_pkg::node_t     stk_rd_data;
  dgcd_pkg::scan_res_t scan_res;
  logic                scan_ld;

  logic                accept;
  logic                in_range;
  logic                out_free;
  dgcd_pkg::depth_t    depth_dec2;

  assign accept   = in_valid && !in_stall;
  assign in_range = ({1'b0, in_edge_from} < NODE_LIMIT) && ({1'b0, in_edge_to} < NODE_LIMIT);
  assign out_free = !out_valid_r || !out_stall;
  assign depth_dec2 = depth_r - dgcd_pkg::DEPTH_W'(2);

  dgcd_adj_mem u_adj (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (adj_req),
    .wr_data (adj_wr_data),
    .rd_data (adj_rd_data)
  );

  dgcd_stack_mem u_stack (
    .clk     (clk),
    .req     (stk_req),
    .rd_data (stk_rd_data)
  );

  dgcd_scan_unit u_scan (
    .clk       (clk),
    .ld        (scan_ld),
    .row       (adj_rd_data),
    .node_mask (NODE_MASK),
    .visited   (visited_r),
    .on_path   (on_path_r),
    .res       (scan_res)
  );

  always_comb begin
    state_nxt     = state_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    dir_nxt       = dir_r;
    visited_nxt   = visited_r;
    on_path_nxt   = on_path_r;
    depth_nxt     = depth_r;
    start_nxt     = start_r;
    top_nxt       = top_r;
    found_nxt     = found_r;
    adj_req       = '0;
    adj_wr_data   = adj_rd_data;
    stk_req       = '0;
    scan_ld       = 1'b0;

    unique case (state_r)
      dgcd_pkg::S_IDLE: begin
        if (accept) begin
          from_nxt = in_edge_from;
          to_nxt   = in_edge_to;
          dir_nxt  = in_directed;
          unique case (in_mode)
            dgcd_pkg::MODE_ADD: begin
              // drop edges that touch a node outside the graph
              if (in_range) begin
                state_nxt = dgcd_pkg::S_ADD_RD1;
              end
            end
            dgcd_pkg::MODE_CHECK: begin
              visited_nxt = '0;
              on_path_nxt = '0;
              depth_nxt   = '0;
              start_nxt   = '0;
              found_nxt   = 1'b0;
              state_nxt   = dgcd_pkg::S_START;
            end
            dgcd_pkg::MODE_CLEAR: begin
              adj_req.clr = 1'b1;
            end
            default: begin
              // unused mode: drop the request
            end
          endcase
        end
      end

      dgcd_pkg::S_ADD_RD1: begin
        adj_req.rd_en   = 1'b1;
        adj_req.rd_addr = from_r;
        state_nxt       = dgcd_pkg::S_ADD_WR1;
      end

      dgcd_pkg::S_ADD_WR1: begin
        adj_req.wr_en   = 1'b1;
        adj_req.wr_addr = from_r;
        adj_wr_data     = adj_rd_data | (dgcd_pkg::MAX_NODES'(1) << to_r);
        state_nxt       = dir_r ? dgcd_pkg::S_IDLE : dgcd_pkg::S_ADD_RD2;
      end

      dgcd_pkg::S_ADD_RD2: begin
        adj_req.rd_en   = 1'b1;
        adj_req.rd_addr = to_r;
        state_nxt       = dgcd_pkg::S_ADD_WR2;
      end

      dgcd_pkg::S_ADD_WR2: begin
        adj_req.wr_en   = 1'b1;
        adj_req.wr_addr = to_r;
        adj_wr_data     = adj_rd_data | (dgcd_pkg::MAX_NODES'(1) << from_r);
        state_nxt       = dgcd_pkg::S_IDLE;
      end

      dgcd_pkg::S_START: begin
        // advance over start nodes; push the first unvisited one
        priority if (start_r == NODE_LIMIT) begin
          found_nxt = 1'b0;
          state_nxt = dgcd_pkg::S_DONE;
        end else if (visited_r[start_r[dgcd_pkg::NODE_W-1:0]]) begin
          start_nxt = start_r + dgcd_pkg::DEPTH_W'(1);
        end else begin
          stk_req.wr_en   = 1'b1;
          stk_req.wr_addr = depth_r[dgcd_pkg::NODE_W-1:0];
          stk_req.wr_data = start_r[dgcd_pkg::NODE_W-1:0];
          depth_nxt       = depth_r + dgcd_pkg::DEPTH_W'(1);
          visited_nxt     = visited_r | (dgcd_pkg::MAX_NODES'(1) << start_r[dgcd_pkg::NODE_W-1:0]);
          on_path_nxt     = on_path_r | (dgcd_pkg::MAX_NODES'(1) << start_r[dgcd_pkg::NODE_W-1:0]);
          top_nxt         = start_r[dgcd_pkg::NODE_W-1:0];
          state_nxt       = dgcd_pkg::S_FETCH;
        end
      end

      dgcd_pkg::S_FETCH: begin
        adj_req.rd_en   = 1'b1;
        adj_req.rd_addr = top_r;
        state_nxt       = dgcd_pkg::S_EVAL;
      end

      dgcd_pkg::S_EVAL: begin
        scan_ld   = 1'b1;
        state_nxt = dgcd_pkg::S_DECIDE;
      end

      dgcd_pkg::S_DECIDE: begin
        priority if (scan_res.conflict) begin
          // an arc back onto the path closes a cycle
          found_nxt = 1'b1;
          state_nxt = dgcd_pkg::S_DONE;
        end else if (scan_res.fresh_any) begin
          if (depth_r[dgcd_pkg::DEPTH_W-1]) begin
            found_nxt = 1'b1;
            state_nxt = dgcd_pkg::S_DONE;
          end else begin
            stk_req.wr_en   = 1'b1;
            stk_req.wr_addr = depth_r[dgcd_pkg::NODE_W-1:0];
            stk_req.wr_data = scan_res.low_idx;
            depth_nxt       = depth_r + dgcd_pkg::DEPTH_W'(1);
            visited_nxt     = visited_r | (dgcd_pkg::MAX_NODES'(1) << scan_res.low_idx);
            on_path_nxt     = on_path_r | (dgcd_pkg::MAX_NODES'(1) << scan_res.low_idx);
            top_nxt         = scan_res.low_idx;
            state_nxt       = dgcd_pkg::S_FETCH;
          end
        end else begin
          // dead end: pop the top node off the path
          on_path_nxt = on_path_r & ~(dgcd_pkg::MAX_NODES'(1) << top_r);
          depth_nxt   = depth_r - dgcd_pkg::DEPTH_W'(1);
          if (depth_r == dgcd_pkg::DEPTH_W'(1)) begin
            start_nxt = start_r + dgcd_pkg::DEPTH_W'(1);
            state_nxt = dgcd_pkg::S_START;
          end else begin
            stk_req.rd_en   = 1'b1;
            stk_req.rd_addr = depth_dec2[dgcd_pkg::NODE_W-1:0];
            state_nxt       = dgcd_pkg::S_POP;
          end
        end
      end

      dgcd_pkg::S_POP: begin
        top_nxt   = stk_rd_data;
        state_nxt = dgcd_pkg::S_FETCH;
      end

      dgcd_pkg::S_DONE: begin
        // hold until the result register frees up
        if (out_free) begin
          state_nxt = dgcd_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = dgcd_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    if (state_r == dgcd_pkg::S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = found_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dgcd_pkg::S_IDLE;
      visited_r   <= '0;
      on_path_r   <= '0;
      depth_r     <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      visited_r   <= visited_nxt;
      on_path_r   <= on_path_nxt;
      depth_r     <= depth_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    from_r      <= from_nxt;
    to_r        <= to_nxt;
    dir_r       <= dir_nxt;
    top_r       <= top_nxt;
    found_r     <= found_nxt;
    out_found_r <= out_found_nxt;
  end

  assign in_stall        = (state_r != dgcd_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_cycle_found = out_found_r;

endmodule
